@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the RTL of the byte pattern scanner.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge, ignored while rst is high.
`define WBPS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked on every rising clk edge, reset included.
`define WBPS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/wbps_pkg.sv @@
// ----------------------------------------------------------------------------
// wbps_pkg
// Widths, sizes and register indexes of the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

  // Longest pattern and width of the region byte counter.
  localparam int PATTERN_MAX = 16;
  localparam int OFFSET_BITS = 32;

  // Derived and fixed sizes.
  localparam int WINDOW_DEPTH = PATTERN_MAX - 1;
  localparam int POS_W        = $clog2(PATTERN_MAX);
  localparam int LEN_W        = 5;
  localparam int DATA_W       = 8;
  localparam int RESULT_W     = 32;
  localparam int PATTERN_W    = 64;
  localparam int CARE_W       = 16;

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CARE_MASK      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPORT_ALL     = 3'd4;

  typedef logic [DATA_W-1:0] byte_t;

endpackage

@@ sv/wbps_if.sv @@
// ----------------------------------------------------------------------------
// wbps_if
// Valid/ready channels of the scanner: the byte stream in, the results out.
// ----------------------------------------------------------------------------

// Input channel: one region byte per word.
interface wbps_in_if;
  import wbps_pkg::*;

  logic          valid;
  logic          ready;
  logic [DATA_W-1:0] data_byte;
  logic          region_end;

  modport source (output valid, output data_byte, output region_end, input ready);
  modport sink   (input valid, input data_byte, input region_end, output ready);
endinterface

// Output channel: one match or end-of-region result per word.
interface wbps_out_if;
  import wbps_pkg::*;

  logic                valid;
  logic                ready;
  logic                match_hit;
  logic [RESULT_W-1:0] match_offset;
  logic                region_done;
  logic [RESULT_W-1:0] match_total;

  modport source (output valid, output match_hit, output match_offset,
                  output region_done, output match_total, input ready);
  modport sink   (input valid, input match_hit, input match_offset,
                  input region_done, input match_total, output ready);
endinterface

@@ sv/wildcard_byte_pattern_scanner_core.sv @@
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner_core
// Searches a byte stream for a masked pattern and reports match offsets and match totals.
// ----------------------------------------------------------------------------
//
//   Channel     Dir  Word contents
//   ----------  ---  -----------------------------------------------------
//   byte_in     in   data_byte, region_end
//   result_out  out  match_hit, match_offset, region_done, match_total
//   cfg_*       in   plain write port, index 0..4, no read-back
//
// One byte is accepted per cycle unless a stalled result holds the input register.
// A byte that yields a result word (a match or a region end) passes through the
// input register into the result register, where the word sits until it is taken.
// The window compare against all pattern positions is combinational.
// rst is synchronous and clears the valid flags of the input and result
// registers, window, byte and match counts and the configuration (report_all is set).
// A stalled result holds the result register and the input register; ready
// toward the byte source follows the result sink combinationally.
//
module wildcard_byte_pattern_scanner_core (
  input  logic                         clk,
  input  logic                         rst,
  wbps_in_if.sink                      byte_in,
  wbps_out_if.source                   result_out,
  input  logic                         cfg_we,
  input  logic [wbps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import wbps_pkg::*;

  // Configuration registers.
  logic [PATTERN_W-1:0] pattern_low;
  logic [PATTERN_W-1:0] pattern_high;
  logic [CARE_W-1:0]    care_mask;
  logic [LEN_W-1:0]     pattern_length;
  logic                 report_all;

  // Input register.
  logic  s1_valid;
  byte_t s1_data;
  logic  s1_end;
  logic  s1_advance;

  // Region state.
  byte_t                byte_window [WINDOW_DEPTH];
  logic [OFFSET_BITS-1:0] bytes_seen;
  logic [RESULT_W-1:0]    matches_found;

  // Result register.
  logic                out_valid;
  logic                out_hit;
  logic [RESULT_W-1:0] out_offset;
  logic                out_done;
  logic [RESULT_W-1:0] out_total;

  // Next-value logic.
  byte_t                  recent [PATTERN_MAX];
  byte_t                  pat    [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] pos_ok;
  logic [OFFSET_BITS-1:0] count_next;
  logic [OFFSET_BITS-1:0] start_offset;
  logic [RESULT_W-1:0]    matches_next;
  logic                   len_ok;
  logic                   hit;
  logic                   report;
  logic                   emit;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      care_mask      <= '0;
      pattern_length <= '0;
      report_all     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PATTERN_LOW:    pattern_low    <= cfg_data[PATTERN_W-1:0];
        CFG_PATTERN_HIGH:   pattern_high   <= cfg_data[PATTERN_W-1:0];
        CFG_CARE_MASK:      care_mask      <= cfg_data[CARE_W-1:0];
        CFG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        CFG_REPORT_ALL:     report_all     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The input register moves on whenever the result register can take a word.
  assign s1_advance    = s1_valid && (!out_valid || result_out.ready);
  assign byte_in.ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_in.ready) begin
      s1_valid <= byte_in.valid;
    end
    if (byte_in.valid && byte_in.ready) begin
      s1_data <= byte_in.data_byte;
      s1_end  <= byte_in.region_end;
    end
  end

  // Newest byte first, followed by the stored window.
  always_comb begin
    recent[0] = s1_data;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      recent[k] = byte_window[k-1];
    end
    for (int j = 0; j < PATTERN_MAX; j++) begin
      pat[j] = (j < 8) ? pattern_low[(j % 8)*DATA_W +: DATA_W]
                       : pattern_high[(j % 8)*DATA_W +: DATA_W];
    end
  end

  // Byte count for this item, saturating at the counter's top.
  assign count_next   = (&bytes_seen) ? bytes_seen : bytes_seen + 1'b1;
  assign start_offset = count_next - OFFSET_BITS'(pattern_length);
  assign len_ok       = (pattern_length != '0) &&
                        (pattern_length <= LEN_W'(PATTERN_MAX)) &&
                        (count_next >= OFFSET_BITS'(pattern_length));

  // Pattern byte j lines up with the byte pattern_length-1-j steps back.
  always_comb begin
    logic [LEN_W-1:0] idx;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      idx = pattern_length - LEN_W'(1) - LEN_W'(j);
      if (LEN_W'(j) >= pattern_length || !care_mask[j]) begin
        pos_ok[j] = 1'b1;
      end else begin
        pos_ok[j] = (recent[idx[POS_W-1:0]] == pat[j]);
      end
    end
  end

  assign hit          = len_ok && (&pos_ok);
  assign report       = hit && (report_all || (matches_found == '0));
  assign matches_next = (report && !(&matches_found)) ? matches_found + 1'b1
                                                      : matches_found;
  assign emit         = report || s1_end;

  // Window, byte count and match count; the last byte of a region clears them.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < WINDOW_DEPTH; k++) begin
        byte_window[k] <= '0;
      end
      bytes_seen    <= '0;
      matches_found <= '0;
    end else if (s1_advance) begin
      if (s1_end) begin
        for (int k = 0; k < WINDOW_DEPTH; k++) begin
          byte_window[k] <= '0;
        end
        bytes_seen    <= '0;
        matches_found <= '0;
      end else begin
        byte_window[0] <= s1_data;
        for (int k = 1; k < WINDOW_DEPTH; k++) begin
          byte_window[k] <= byte_window[k-1];
        end
        bytes_seen    <= count_next;
        matches_found <= matches_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= emit;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_advance && emit) begin
      out_hit    <= report;
      out_offset <= report ? RESULT_W'(start_offset) : '0;
      out_done   <= s1_end;
      out_total  <= matches_next;
    end
  end

  assign result_out.valid        = out_valid;
  assign result_out.match_hit    = out_hit;
  assign result_out.match_offset = out_offset;
  assign result_out.region_done  = out_done;
  assign result_out.match_total  = out_total;

  // Checks.
`include "assert_macros.svh"

  `WBPS_ASSERT(a_end_clears_region, s1_advance && s1_end |=> bytes_seen == '0 && matches_found == '0, "region state not cleared after last byte")
  `WBPS_ASSERT(a_hit_counted, out_valid && out_hit |-> out_total != '0, "reported match not counted")
  `WBPS_ASSERT_ALWAYS(a_empty_region_no_matches, bytes_seen == '0 |-> matches_found == '0, "matches without bytes")

endmodule
